### rtl/qrv_pkg.sv
// shared widths, constants and helpers for the quaternion vector rotation block
// no dependencies
package qrv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int THR_W         = 16;
    localparam int SQ_W          = 64;
    localparam int ROOT_W        = SQ_W / 2;
    localparam int QLEN_W        = ROOT_W + 1;
    localparam int SQRT_STAGES   = ROOT_W;

    // latency without the divider stages: input, square, sum, root, two products, scale
    localparam int PIPE_BASE     = 3 + SQRT_STAGES + 6;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1);

    // magnitude of a signed word, most negative value included
    function automatic logic [DATA_W-1:0] mag32(input logic signed [DATA_W-1:0] x);
        return x[DATA_W-1] ? DATA_W'(-x) : DATA_W'(x);
    endfunction

endpackage

### rtl/qrv_pipe.sv
// fixed-length delay line for side data that travels along the pipeline
// no dependencies
module qrv_pipe #(
    parameter int W = 1,
    parameter int D = 1
) (
    input  logic         clk,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] stage_reg [D];

    always_ff @(posedge clk)
    begin
        stage_reg[0] <= din;
        for (int i = 1; i < D; i++)
        begin
            stage_reg[i] <= stage_reg[i-1];
        end
    end

    assign dout = stage_reg[D-1];

endmodule

### rtl/qrv_sqrt.sv
// pipelined integer floor square root, one root bit per stage
// depends on qrv_pkg
module qrv_sqrt (
    input  logic                      clk,
    input  logic [qrv_pkg::SQ_W-1:0]   radicand,
    output logic [qrv_pkg::ROOT_W-1:0] root
);

    localparam int N = qrv_pkg::SQRT_STAGES;
    localparam int W = qrv_pkg::SQ_W;

    logic [W-1:0] x_reg [N];
    logic [W-1:0] r_reg [N];

    for (genvar s = 0; s < N; s++)
    begin : g_stage
        localparam logic [W-1:0] BIT = W'(1) << (2 * (N - 1 - s));
        logic [W-1:0] x_prev, r_prev, x_next, r_next;
        logic [W:0]   trial;

        if (s == 0)
        begin : g_first
            assign x_prev = radicand;
            assign r_prev = '0;
        end
        else
        begin : g_rest
            assign x_prev = x_reg[s-1];
            assign r_prev = r_reg[s-1];
        end

        always_comb
        begin
            trial = {1'b0, r_prev} + {1'b0, BIT};
            if ({1'b0, x_prev} >= trial)
            begin
                x_next = x_prev - trial[W-1:0];
                r_next = (r_prev >> 1) + BIT;
            end
            else
            begin
                x_next = x_prev;
                r_next = r_prev >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            x_reg[s] <= x_next;
            r_reg[s] <= r_next;
        end
    end

    assign root = r_reg[N-1][qrv_pkg::ROOT_W-1:0];

endmodule

### rtl/qrv_div.sv
// pipelined restoring divider for (|a| << frac) / den, one quotient bit per stage
// depends on qrv_pkg; quotient known to stay within frac+1 bits
module qrv_div #(
    parameter int FRAC_BITS = qrv_pkg::FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic [qrv_pkg::DATA_W-1:0]       num,
    input  logic                             neg,
    input  logic [qrv_pkg::QLEN_W-1:0]       den,
    output logic signed [FRAC_BITS+1:0]      quo
);

    localparam int NS    = FRAC_BITS + 1;
    localparam int DEN_W = qrv_pkg::QLEN_W;
    localparam int REM_W = DEN_W + 1;

    logic [REM_W-1:0] rem_reg [NS];
    logic [NS-1:0]    q_reg   [NS];
    logic [DEN_W-1:0] den_reg [NS];
    logic             neg_reg [NS];

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [REM_W-1:0] rem_prev, rem2, rem_next;
        logic [NS-1:0]    q_prev;
        logic [DEN_W-1:0] den_prev;
        logic             neg_prev, bit_in, ge;

        if (s == 0)
        begin : g_first
            assign rem_prev = REM_W'(num >> 1);
            assign q_prev   = '0;
            assign den_prev = den;
            assign neg_prev = neg;
            assign bit_in   = num[0];
        end
        else
        begin : g_rest
            assign rem_prev = rem_reg[s-1];
            assign q_prev   = q_reg[s-1];
            assign den_prev = den_reg[s-1];
            assign neg_prev = neg_reg[s-1];
            assign bit_in   = 1'b0;
        end

        always_comb
        begin
            rem2     = {rem_prev[REM_W-2:0], bit_in};
            ge       = rem2 >= {1'b0, den_prev};
            rem_next = ge ? rem2 - {1'b0, den_prev} : rem2;
        end

        always_ff @(posedge clk)
        begin
            rem_reg[s] <= rem_next;
            q_reg[s]   <= {q_prev[NS-2:0], ge};
            den_reg[s] <= den_prev;
            neg_reg[s] <= neg_prev;
        end
    end

    assign quo = neg_reg[NS-1] ? -$signed({1'b0, q_reg[NS-1]}) : $signed({1'b0, q_reg[NS-1]});

endmodule

### rtl/qrv_ham.sv
// two-stage hamilton product: products registered, then sum and truncating shift
// depends on qrv_pkg for the default fraction width
module qrv_ham #(
    parameter int FRAC_BITS = qrv_pkg::FRAC_BITS_DEF,
    parameter int AW        = 32,
    parameter int BW        = 32,
    parameter int OW        = AW + BW + 2 - FRAC_BITS
) (
    input  logic                 clk,
    input  logic signed [AW-1:0] a [4],
    input  logic signed [BW-1:0] b [4],
    output logic signed [OW-1:0] o [4]
);

    localparam int PW = AW + BW;
    localparam int SW = PW + 2;

    logic signed [PW-1:0] pr_reg [16];
    logic signed [SW-1:0] s [4];
    logic signed [OW-1:0] o_reg [4];

    function automatic logic signed [OW-1:0] shr_trunc(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        logic [SW-1:0] sh;
        m  = v[SW-1] ? SW'(-v) : SW'(v);
        sh = m >> FRAC_BITS;
        return v[SW-1] ? OW'(-sh) : OW'(sh);
    endfunction

    // x, y, z, w order; w is the scalar
    always_ff @(posedge clk)
    begin
        pr_reg[0]  <= a[3] * b[0];
        pr_reg[1]  <= a[0] * b[3];
        pr_reg[2]  <= a[1] * b[2];
        pr_reg[3]  <= a[2] * b[1];
        pr_reg[4]  <= a[3] * b[1];
        pr_reg[5]  <= a[0] * b[2];
        pr_reg[6]  <= a[1] * b[3];
        pr_reg[7]  <= a[2] * b[0];
        pr_reg[8]  <= a[3] * b[2];
        pr_reg[9]  <= a[0] * b[1];
        pr_reg[10] <= a[1] * b[0];
        pr_reg[11] <= a[2] * b[3];
        pr_reg[12] <= a[3] * b[3];
        pr_reg[13] <= a[0] * b[0];
        pr_reg[14] <= a[1] * b[1];
        pr_reg[15] <= a[2] * b[2];
    end

    always_comb
    begin
        s[0] = SW'(pr_reg[0]) + SW'(pr_reg[1]) + SW'(pr_reg[2]) - SW'(pr_reg[3]);
        s[1] = SW'(pr_reg[4]) - SW'(pr_reg[5]) + SW'(pr_reg[6]) + SW'(pr_reg[7]);
        s[2] = SW'(pr_reg[8]) + SW'(pr_reg[9]) - SW'(pr_reg[10]) + SW'(pr_reg[11]);
        s[3] = SW'(pr_reg[12]) - SW'(pr_reg[13]) - SW'(pr_reg[14]) - SW'(pr_reg[15]);
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            o_reg[k] <= shr_trunc(s[k]);
        end
    end

    assign o = o_reg;

endmodule

### rtl/qrv_scale.sv
// scale by the vector length with truncating shift and 32-bit saturation
// depends on qrv_pkg; two stages, the wide product split in two partial products
module qrv_scale #(
    parameter int FRAC_BITS = qrv_pkg::FRAC_BITS_DEF,
    parameter int TW        = 48
) (
    input  logic                              clk,
    input  logic signed [TW-1:0]              t,
    input  logic [qrv_pkg::ROOT_W-1:0]        len,
    output logic [qrv_pkg::DATA_W-1:0]        res
);

    localparam int LW   = qrv_pkg::ROOT_W;
    localparam int HI_W = TW - 32;
    localparam int FW   = TW + LW;

    logic [TW-1:0]        m;
    logic                 neg_reg;
    logic [31+LW:0]       plo_reg;
    logic [HI_W+LW-1:0]   phi_reg;
    logic [FW-1:0]        full, s;
    logic [31:0]          res_next, res_reg;

    assign m = t[TW-1] ? TW'(-t) : TW'(t);

    always_ff @(posedge clk)
    begin
        neg_reg <= t[TW-1];
        plo_reg <= m[31:0] * len;
        phi_reg <= m[TW-1:32] * len;
    end

    always_comb
    begin
        full = {phi_reg, 32'b0} + FW'(plo_reg);
        s    = full >> FRAC_BITS;
        if (neg_reg)
        begin
            res_next = (s > FW'(33'h0_8000_0000)) ? 32'h8000_0000 : ~s[31:0] + 32'd1;
        end
        else
        begin
            res_next = (s > FW'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : s[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign res = res_reg;

endmodule

### rtl/quaternion_rotate_vector.sv
// top level of the quaternion vector rotation pipeline
// depends on qrv_pkg, qrv_pipe, qrv_sqrt, qrv_div, qrv_ham, qrv_scale
//
// rotates vec by quat as q * v * conj(q), signed fixed point with FRAC_BITS fraction
// bits. one item per cycle is taken: start is accepted whenever busy is low, and busy is
// always low. each result appears on rot_x/y/z for one cycle with done high, in order.
// the receiver cannot hold results off and none is needed. the pipeline runs through
// the input, square and sum registers, the two 32-stage square roots (one root bit per
// stage) and the FRAC_BITS+1 stage dividers (one quotient bit per stage), then two
// hamilton products and the length scaling at two stages each. length_threshold is
// written through cfg_valid/cfg_data; cfg_ready is always high and writes belong to
// idle time only.
module quaternion_rotate_vector #(
    parameter int FRAC_BITS = qrv_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [qrv_pkg::DATA_W-1:0]   quat_x,
    input  logic signed [qrv_pkg::DATA_W-1:0]   quat_y,
    input  logic signed [qrv_pkg::DATA_W-1:0]   quat_z,
    input  logic signed [qrv_pkg::DATA_W-1:0]   quat_w,
    input  logic signed [qrv_pkg::DATA_W-1:0]   vec_x,
    input  logic signed [qrv_pkg::DATA_W-1:0]   vec_y,
    input  logic signed [qrv_pkg::DATA_W-1:0]   vec_z,
    output logic                                done,
    output logic signed [qrv_pkg::DATA_W-1:0]   rot_x,
    output logic signed [qrv_pkg::DATA_W-1:0]   rot_y,
    output logic signed [qrv_pkg::DATA_W-1:0]   rot_z,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [qrv_pkg::THR_W-1:0]           cfg_data
);

    localparam int DW    = qrv_pkg::DATA_W;
    localparam int SQW   = qrv_pkg::SQ_W;
    localparam int RW    = qrv_pkg::ROOT_W;
    localparam int QLW   = qrv_pkg::QLEN_W;
    localparam int DIV_W = FRAC_BITS + 2;
    localparam int P_W   = DW + DIV_W + 2 - FRAC_BITS;
    localparam int C_W   = DW + 1;
    localparam int T_W   = P_W + C_W + 2 - FRAC_BITS;
    localparam int LAT   = qrv_pkg::PIPE_BASE + FRAC_BITS;
    localparam int VD    = LAT + 1;
    localparam int SB_W  = 4 * DW + RW + 2;

    // control: never stalls
    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // threshold register
    logic [qrv_pkg::THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= qrv_pkg::THR_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            thr_reg <= cfg_data;
        end
    end

    // valid bits, one per pipeline position; bit 0 marks the input registers
    logic [VD-1:0] vld_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[VD-2:0], start && !busy};
        end
    end

    assign done = vld_reg[VD-1];

    // input registers
    logic signed [DW-1:0] q_reg [4];
    logic signed [DW-1:0] v_reg [3];

    always_ff @(posedge clk)
    begin
        q_reg[0] <= quat_x;
        q_reg[1] <= quat_y;
        q_reg[2] <= quat_z;
        q_reg[3] <= quat_w;
        v_reg[0] <= vec_x;
        v_reg[1] <= vec_y;
        v_reg[2] <= vec_z;
    end

    // squares of the magnitudes
    logic [SQW-1:0] vsq_reg [3];
    logic [SQW-1:0] qsq_reg [4];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
        begin
            vsq_reg[i] <= qrv_pkg::mag32(v_reg[i]) * qrv_pkg::mag32(v_reg[i]);
        end
        for (int i = 0; i < 4; i++)
        begin
            qsq_reg[i] <= qrv_pkg::mag32(q_reg[i]) * qrv_pkg::mag32(q_reg[i]);
        end
    end

    // sums of squares; the quaternion sum only overflows for the all most-negative case
    logic [SQW-1:0] vsum_reg, qsum_reg;
    logic           qcarry_reg;
    logic [SQW+1:0] qsum_wide;

    assign qsum_wide = (SQW+2)'(qsq_reg[0]) + (SQW+2)'(qsq_reg[1])
                     + (SQW+2)'(qsq_reg[2]) + (SQW+2)'(qsq_reg[3]);

    always_ff @(posedge clk)
    begin
        vsum_reg   <= vsq_reg[0] + vsq_reg[1] + vsq_reg[2];
        qsum_reg   <= qsum_wide[SQW-1:0];
        qcarry_reg <= |qsum_wide[SQW+1:SQW];
    end

    // lengths
    logic [RW-1:0] vroot, qroot;

    qrv_sqrt u_sqrt_v (.clk(clk), .radicand(vsum_reg), .root(vroot));
    qrv_sqrt u_sqrt_q (.clk(clk), .radicand(qsum_reg), .root(qroot));

    // operands delayed to meet the roots
    logic [7*DW-1:0] qv_d;
    logic            qcarry_d;

    qrv_pipe #(.W(7 * DW), .D(qrv_pkg::SQRT_STAGES + 2)) u_pipe_qv (
        .clk(clk),
        .din({q_reg[3], q_reg[2], q_reg[1], q_reg[0], v_reg[2], v_reg[1], v_reg[0]}),
        .dout(qv_d)
    );

    qrv_pipe #(.W(1), .D(qrv_pkg::SQRT_STAGES)) u_pipe_carry (
        .clk(clk), .din(qcarry_reg), .dout(qcarry_d)
    );

    logic signed [DW-1:0] q_s [4];
    logic signed [DW-1:0] v_s [3];
    logic [QLW-1:0]       qlen;
    logic                 vdiv, qdiv;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            v_s[i] = qv_d[DW*i +: DW];
        end
        for (int i = 0; i < 4; i++)
        begin
            q_s[i] = qv_d[DW*(3+i) +: DW];
        end
        qlen = qcarry_d ? {1'b1, {RW{1'b0}}} : {1'b0, qroot};
        vdiv = vroot > RW'(thr_reg);
        qdiv = qlen > QLW'(thr_reg);
    end

    // normalization of the vector and scaled conjugate of the quaternion
    logic [DW-1:0]           div_num [7];
    logic                    div_neg [7];
    logic [QLW-1:0]          div_den [7];
    logic signed [DIV_W-1:0] div_quo [7];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            div_num[i]   = qrv_pkg::mag32(v_s[i]);
            div_neg[i]   = v_s[i][DW-1];
            div_den[i]   = {1'b0, vroot};
            div_num[3+i] = qrv_pkg::mag32(q_s[i]);
            div_neg[3+i] = !q_s[i][DW-1];
            div_den[3+i] = qlen;
        end
        div_num[6] = qrv_pkg::mag32(q_s[3]);
        div_neg[6] = q_s[3][DW-1];
        div_den[6] = qlen;
    end

    for (genvar i = 0; i < 7; i++)
    begin : g_div
        qrv_div #(.FRAC_BITS(FRAC_BITS)) u_div (
            .clk(clk), .num(div_num[i]), .neg(div_neg[i]), .den(div_den[i]), .quo(div_quo[i])
        );
    end

    logic [SB_W-1:0] sb_d;

    qrv_pipe #(.W(SB_W), .D(FRAC_BITS + 1)) u_pipe_sb (
        .clk(clk),
        .din({q_s[3], q_s[2], q_s[1], q_s[0], vroot, vdiv, qdiv}),
        .dout(sb_d)
    );

    // select normalized or zero vector, divided or plain conjugate
    logic signed [DW-1:0]    q_d [4];
    logic [RW-1:0]           vlen_d;
    logic                    vdiv_d, qdiv_d;
    logic signed [DIV_W-1:0] n [4];
    logic signed [C_W-1:0]   c [4];

    always_comb
    begin
        qdiv_d = sb_d[0];
        vdiv_d = sb_d[1];
        vlen_d = sb_d[2 +: RW];
        for (int i = 0; i < 4; i++)
        begin
            q_d[i] = sb_d[2 + RW + DW*i +: DW];
        end
        for (int i = 0; i < 3; i++)
        begin
            n[i] = vdiv_d ? div_quo[i] : '0;
            c[i] = qdiv_d ? C_W'(div_quo[3+i]) : -C_W'(q_d[i]);
        end
        n[3] = '0;
        c[3] = qdiv_d ? C_W'(div_quo[6]) : C_W'(q_d[3]);
    end

    // p = q * n
    logic signed [P_W-1:0] p [4];

    qrv_ham #(.FRAC_BITS(FRAC_BITS), .AW(DW), .BW(DIV_W), .OW(P_W)) u_ham_p (
        .clk(clk), .a(q_d), .b(n), .o(p)
    );

    // conjugate delayed to meet p
    logic [4*C_W-1:0]      c_d;
    logic signed [C_W-1:0] c_x [4];

    qrv_pipe #(.W(4 * C_W), .D(2)) u_pipe_c (
        .clk(clk), .din({c[3], c[2], c[1], c[0]}), .dout(c_d)
    );

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            c_x[i] = c_d[C_W*i +: C_W];
        end
    end

    // t = p * c; only the xyz part goes on
    logic signed [T_W-1:0] t [4];

    qrv_ham #(.FRAC_BITS(FRAC_BITS), .AW(P_W), .BW(C_W), .OW(T_W)) u_ham_t (
        .clk(clk), .a(p), .b(c_x), .o(t)
    );

    logic [RW-1:0] vlen_s;

    qrv_pipe #(.W(RW), .D(4)) u_pipe_len (.clk(clk), .din(vlen_d), .dout(vlen_s));

    // scale by the vector length and saturate
    logic [DW-1:0] rot [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_scale
        qrv_scale #(.FRAC_BITS(FRAC_BITS), .TW(T_W)) u_scale (
            .clk(clk), .t(t[i]), .len(vlen_s), .res(rot[i])
        );
    end

    assign rot_x = $signed(rot[0]);
    assign rot_y = $signed(rot[1]);
    assign rot_z = $signed(rot[2]);

endmodule

### rtl/qrv_checker.sv
// port-level checks of the rotation pipeline: fixed latency, no spurious result and zero-vector result
// depends on qrv_pkg; bound to quaternion_rotate_vector at the end of this file
module qrv_checker #(
    parameter int FRAC_BITS = qrv_pkg::FRAC_BITS_DEF
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               start,
    input logic                               busy,
    input logic signed [qrv_pkg::DATA_W-1:0]  quat_x,
    input logic signed [qrv_pkg::DATA_W-1:0]  quat_y,
    input logic signed [qrv_pkg::DATA_W-1:0]  quat_z,
    input logic signed [qrv_pkg::DATA_W-1:0]  quat_w,
    input logic signed [qrv_pkg::DATA_W-1:0]  vec_x,
    input logic signed [qrv_pkg::DATA_W-1:0]  vec_y,
    input logic signed [qrv_pkg::DATA_W-1:0]  vec_z,
    input logic                               done,
    input logic signed [qrv_pkg::DATA_W-1:0]  rot_x,
    input logic signed [qrv_pkg::DATA_W-1:0]  rot_y,
    input logic signed [qrv_pkg::DATA_W-1:0]  rot_z,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic [qrv_pkg::THR_W-1:0]          cfg_data
);

    // sampled edges from the start transfer to the edge that takes the result
    localparam int LAT   = qrv_pkg::PIPE_BASE + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(LAT + 1);

    logic [CNT_W-1:0] warm_reg;
    logic             warm;
    logic             xfer;
    logic             vzero;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warm_reg <= '0;
        end
        else if (warm_reg != CNT_W'(LAT))
        begin
            warm_reg <= warm_reg + CNT_W'(1);
        end
    end

    assign warm  = warm_reg == CNT_W'(LAT);
    assign xfer  = start && !busy;
    assign vzero = (vec_x == '0) && (vec_y == '0) && (vec_z == '0);

    // every start transfer gives a result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        xfer |-> ##LAT done)
        else $error("result missing after start transfer");

    // no result without a start transfer the fixed latency earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (warm && $past(xfer, LAT)))
        else $error("result without matching start transfer");

    // a zero vector rotates to zero
    a_zero_vec: assert property (@(posedge clk) disable iff (!rst_n)
        (done && warm && $past(vzero, LAT)) |->
            ((rot_x == '0) && (rot_y == '0) && (rot_z == '0)))
        else $error("zero vector gave a nonzero result");

    // unused here beyond the bind
    logic unused_ok;
    assign unused_ok = ^{quat_x, quat_y, quat_z, quat_w, cfg_valid, cfg_ready, cfg_data};

endmodule

bind quaternion_rotate_vector qrv_checker #(.FRAC_BITS(FRAC_BITS)) u_qrv_checker (.*);

### test/tb_quaternion_rotate_vector.sv
// testbench for quaternion_rotate_vector: directed table then random rotations
// checked field by field against typed results or an in-bench fixed-point predictor
// depends on qrv_pkg and the quaternion_rotate_vector rtl
module tb_quaternion_rotate_vector;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = qrv_pkg::FRAC_BITS_DEF;
    // base of the wait that drain adds once nothing is pending
    localparam int LATENCY = 41 + FRAC;

    typedef logic signed [127:0] wide_t;
    typedef logic signed [qrv_pkg::DATA_W-1:0] word_t;

    typedef struct {
        word_t qx, qy, qz, qw;
        word_t vx, vy, vz;
    } rot_in_t;

    typedef struct {
        word_t x, y, z;
    } rot_out_t;

    // directed row: the typed result is used only where has_typed is set
    typedef struct {
        rot_in_t  stim;
        bit       has_typed;
        rot_out_t typed;
    } row_t;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    word_t      quat_x, quat_y, quat_z, quat_w;
    word_t      vec_x, vec_y, vec_z;
    logic       done;
    word_t      rot_x, rot_y, rot_z;
    logic       cfg_valid;
    logic       cfg_ready;
    logic [qrv_pkg::THR_W-1:0] cfg_data;

    quaternion_rotate_vector u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .quat_x    (quat_x),
        .quat_y    (quat_y),
        .quat_z    (quat_z),
        .quat_w    (quat_w),
        .vec_x     (vec_x),
        .vec_y     (vec_y),
        .vec_z     (vec_z),
        .done      (done),
        .rot_x     (rot_x),
        .rot_y     (rot_y),
        .rot_z     (rot_z),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // predictor copy of the threshold register
    logic [qrv_pkg::THR_W-1:0] thr_shadow;

    rot_out_t rotations_pending[$];
    rot_out_t typed_now;
    bit       typed_flag;
    int       errors;
    int       items_sent;
    int       results_seen;
    int       short_vec_items;

    // ---------------------------------------------------------------
    // fixed-point predictor
    // ---------------------------------------------------------------
    function automatic wide_t abs_w(wide_t x);
        return (x < 0) ? -x : x;
    endfunction

    // shift right by the fraction width, truncating toward zero
    function automatic wide_t drop_frac(wide_t x);
        wide_t m;
        m = abs_w(x) >> FRAC;
        return (x < 0) ? -m : m;
    endfunction

    function automatic wide_t div_by_len(wide_t a, wide_t den);
        wide_t m;
        m = (abs_w(a) << FRAC) / den;
        return (a < 0) ? -m : m;
    endfunction

    function automatic logic [63:0] floor_root(logic [63:0] x);
        logic [63:0] res;
        logic [63:0] b;
        res = '0;
        b = 64'd1 << 62;
        while (b > x)
            b = b >> 2;
        while (b != 0)
        begin
            if (x >= res + b)
            begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    // hamilton product, order x y z w
    function automatic void ham(input wide_t a[4], input wide_t b[4], output wide_t o[4]);
        o[0] = drop_frac(a[3]*b[0] + a[0]*b[3] + a[1]*b[2] - a[2]*b[1]);
        o[1] = drop_frac(a[3]*b[1] - a[0]*b[2] + a[1]*b[3] + a[2]*b[0]);
        o[2] = drop_frac(a[3]*b[2] + a[0]*b[1] - a[1]*b[0] + a[2]*b[3]);
        o[3] = drop_frac(a[3]*b[3] - a[0]*b[0] - a[1]*b[1] - a[2]*b[2]);
    endfunction

    // r times the vector length, back to 32 bits with saturation
    function automatic word_t scale_back(wide_t r, wide_t len);
        wide_t s;
        s = (abs_w(r) * len) >> FRAC;
        if (r < 0)
            return (s > (wide_t'(1) <<< 31)) ? word_t'(32'h8000_0000) : word_t'(-s);
        return (s > wide_t'(32'h7FFF_FFFF)) ? word_t'(32'h7FFF_FFFF) : word_t'(s);
    endfunction

    function automatic rot_out_t rotate_predict(rot_in_t it, logic [qrv_pkg::THR_W-1:0] thr);
        wide_t q[4], n[4], c[4], p[4], t[4], v[3];
        wide_t vsum, qsum, vlen, qlen;
        rot_out_t r;
        q[0] = wide_t'(it.qx);
        q[1] = wide_t'(it.qy);
        q[2] = wide_t'(it.qz);
        q[3] = wide_t'(it.qw);
        v[0] = wide_t'(it.vx);
        v[1] = wide_t'(it.vy);
        v[2] = wide_t'(it.vz);
        vsum = v[0]*v[0] + v[1]*v[1] + v[2]*v[2];
        qsum = q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3];
        vlen = wide_t'(floor_root(vsum[63:0]));
        // only the all most-negative quaternion reaches 2^64
        qlen = (qsum >= (wide_t'(1) <<< 64)) ? (wide_t'(1) <<< 32)
                                             : wide_t'(floor_root(qsum[63:0]));
        for (int i = 0; i < 3; i++)
            n[i] = (vlen > wide_t'(thr)) ? div_by_len(v[i], vlen) : wide_t'(0);
        n[3] = 0;
        c[0] = -q[0];
        c[1] = -q[1];
        c[2] = -q[2];
        c[3] = q[3];
        if (qlen > wide_t'(thr))
            for (int i = 0; i < 4; i++)
                c[i] = div_by_len(c[i], qlen);
        ham(q, n, p);
        ham(p, c, t);
        r.x = scale_back(t[0], vlen);
        r.y = scale_back(t[1], vlen);
        r.z = scale_back(t[2], vlen);
        return r;
    endfunction

    // ---------------------------------------------------------------
    // input transfer capture and result checking, both at the rising edge
    // ---------------------------------------------------------------
    always @(posedge clk)
    begin
        rot_in_t  it;
        rot_out_t e;
        logic [63:0] vs;
        if (rst_n && start && !busy)
        begin
            it.qx = quat_x; it.qy = quat_y; it.qz = quat_z; it.qw = quat_w;
            it.vx = vec_x;  it.vy = vec_y;  it.vz = vec_z;
            e = typed_flag ? typed_now : rotate_predict(it, thr_shadow);
            rotations_pending.push_back(e);
            items_sent++;
            vs = 64'(wide_t'(it.vx)*it.vx + wide_t'(it.vy)*it.vy + wide_t'(it.vz)*it.vz);
            if (floor_root(vs) <= 64'(thr_shadow))
                short_vec_items++;
        end
    end

    always @(posedge clk)
    begin
        rot_out_t e;
        if (rst_n && done)
        begin
            results_seen++;
            if (rotations_pending.size() == 0)
            begin
                $error("result with nothing pending: %0d %0d %0d", rot_x, rot_y, rot_z);
                errors++;
            end
            else
            begin
                e = rotations_pending.pop_front();
                if (rot_x !== e.x)
                begin
                    $error("rot_x expected %0d actual %0d", e.x, rot_x);
                    errors++;
                end
                if (rot_y !== e.y)
                begin
                    $error("rot_y expected %0d actual %0d", e.y, rot_y);
                    errors++;
                end
                if (rot_z !== e.z)
                begin
                    $error("rot_z expected %0d actual %0d", e.z, rot_z);
                    errors++;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    bit no_gaps;

    // idle cycles between transfers: mostly none or short, a few long
    task automatic idle_gap();
        int r;
        int n;
        r = $urandom_range(99);
        if (no_gaps || r < 55)
            n = 0;
        else if (r < 93)
            n = $urandom_range(3, 1);
        else
            n = $urandom_range(40, 10);
        if (n > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // one start transfer; start stays high if the next item follows at once
    task automatic send_item(rot_in_t it, bit has_typed, rot_out_t typed);
        @(negedge clk);
        quat_x = it.qx; quat_y = it.qy; quat_z = it.qz; quat_w = it.qw;
        vec_x = it.vx;  vec_y = it.vy;  vec_z = it.vz;
        typed_flag = has_typed;
        typed_now = typed;
        start = 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        idle_gap();
    endtask

    task automatic drain();
        @(negedge clk);
        start = 1'b0;
        while (rotations_pending.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    // threshold write, only with the pipeline empty
    task automatic write_threshold(logic [qrv_pkg::THR_W-1:0] val);
        drain();
        @(negedge clk);
        cfg_data = val;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        thr_shadow = val;
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_data = $urandom();
    endtask

    // random field: full range, near unit scale, small, or an extreme
    function automatic word_t rand_field(int mode);
        int r;
        r = $urandom_range(99);
        if (mode == 0 || r < 10)
            return word_t'($urandom());
        if (r < 18)
        begin
            case ($urandom_range(4))
                0: return word_t'(32'h8000_0000);
                1: return word_t'(32'h7FFF_FFFF);
                2: return word_t'(0);
                3: return word_t'(-1);
                default: return word_t'(1);
            endcase
        end
        if (r < 30)
            return word_t'($signed($urandom_range(131071)) - 65535) <<< $urandom_range(6);
        // small magnitudes around the threshold region
        if (r < 40)
            return word_t'($signed($urandom_range(512)) - 256);
        return word_t'($signed($urandom_range(262143)) - 131071);
    endfunction

    task automatic random_block(int count);
        rot_in_t it;
        rot_out_t none;
        int mode;
        none = '{default: '0};
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 0)
                no_gaps = ($urandom_range(3) == 0);
            mode = ($urandom_range(4) == 0) ? 0 : 1;
            it.qx = rand_field(mode); it.qy = rand_field(mode);
            it.qz = rand_field(mode); it.qw = rand_field(mode);
            it.vx = rand_field(mode); it.vy = rand_field(mode);
            it.vz = rand_field(mode);
            // unit-ish quaternions, the common use
            if ($urandom_range(2) == 0)
            begin
                it.qw = word_t'($signed($urandom_range(131072)) - 65536);
                it.qx = word_t'($signed($urandom_range(131072)) - 65536);
            end
            send_item(it, 1'b0, none);
        end
        no_gaps = 1'b0;
    endtask

    // ---------------------------------------------------------------
    // directed table
    // ---------------------------------------------------------------
    localparam word_t ONE  = 32'sd65536;
    localparam word_t MINW = 32'sh8000_0000;
    localparam word_t MAXW = 32'sh7FFF_FFFF;

    row_t dir_rows[$];

    task automatic add_row(word_t qx, word_t qy, word_t qz, word_t qw,
                           word_t vx, word_t vy, word_t vz,
                           bit has_typed, word_t ex, word_t ey, word_t ez);
        row_t r;
        r.stim = '{qx, qy, qz, qw, vx, vy, vz};
        r.has_typed = has_typed;
        r.typed = '{ex, ey, ez};
        dir_rows.push_back(r);
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        quat_x = '0; quat_y = '0; quat_z = '0; quat_w = '0;
        vec_x = '0;  vec_y = '0;  vec_z = '0;
        cfg_valid = 1'b0;
        cfg_data = '0;
        typed_flag = 1'b0;
        typed_now = '{default: '0};
        thr_shadow = qrv_pkg::THR_RESET;
        errors = 0;
        items_sent = 0;
        results_seen = 0;
        short_vec_items = 0;
        no_gaps = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // zero vector: short vector gives all zeros
        add_row(0, 0, 0, ONE, 0, 0, 0, 1'b1, 0, 0, 0);
        // identity quaternion leaves a unit vector alone
        add_row(0, 0, 0, ONE, ONE, 0, 0, 1'b1, ONE, 0, 0);
        add_row(0, 0, 0, ONE, 0, 0, ONE, 1'b1, 0, 0, ONE);
        // vector length of one raw unit, not above the reset threshold
        add_row(MAXW, MINW, MAXW, MINW, 1, 0, 0, 1'b1, 0, 0, 0);
        add_row(0, 0, 0, ONE, 0, -1, 0, 1'b1, 0, 0, 0);
        // short quaternions: the zero quaternion and one of raw length one, plain conjugate path
        add_row(0, 0, 0, 0, ONE, ONE, ONE, 1'b0, 0, 0, 0);
        add_row(1, 0, 0, 0, MAXW, MINW, MAXW, 1'b0, 0, 0, 0);
        // all most-negative quaternion
        add_row(MINW, MINW, MINW, MINW, ONE, 2*ONE, -3*ONE, 1'b0, 0, 0, 0);
        add_row(MINW, MINW, MINW, MINW, MINW, MINW, MINW, 1'b0, 0, 0, 0);
        // field extremes, saturation
        add_row(MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, MAXW, 1'b0, 0, 0, 0);
        add_row(MINW, MAXW, MINW, MAXW, MINW, MAXW, MINW, 1'b0, 0, 0, 0);
        add_row(0, 0, ONE, 0, MAXW, 0, MINW, 1'b0, 0, 0, 0);
        add_row(-1, -1, -1, -1, -1, -1, -1, 1'b0, 0, 0, 0);
        // 90 degrees about z and about x, roughly, then 180 degrees about x
        add_row(0, 0, 32'sd46341, 32'sd46341, ONE, 0, 0, 1'b0, 0, 0, 0);
        add_row(32'sd46341, 0, 0, 32'sd46341, 0, ONE, 0, 1'b0, 0, 0, 0);
        add_row(ONE, 0, 0, 0, 0, 5*ONE, -7*ONE, 1'b0, 0, 0, 0);

        foreach (dir_rows[i])
            send_item(dir_rows[i].stim, dir_rows[i].has_typed, dir_rows[i].typed);

        // random part over several threshold settings, extremes included
        random_block(400);
        write_threshold(16'd0);
        random_block(350);
        write_threshold(16'hFFFF);
        random_block(350);
        write_threshold(16'(1 << FRAC - 4));
        random_block(250);
        write_threshold(16'($urandom()));
        random_block(250);

        drain();
        $display("tb: %0d rotations sent, %0d results checked, %0d with short vector",
                 items_sent, results_seen, short_vec_items);
        $display("tb: thresholds 1, 0, 65535, 4096 and one random value covered");
        if (errors == 0)
            $display("** quaternion_rotate_vector: PASSED **");
        else
            $display("** quaternion_rotate_vector: FAILED **");
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial
    begin
        #4_000_000;
        $display("** quaternion_rotate_vector: FAILED **");
        $finish;
    end

endmodule

### filelist.f
rtl/qrv_pkg.sv
rtl/qrv_pipe.sv
rtl/qrv_sqrt.sv
rtl/qrv_div.sv
rtl/qrv_ham.sv
rtl/qrv_scale.sv
rtl/quaternion_rotate_vector.sv
rtl/qrv_checker.sv
test/tb_quaternion_rotate_vector.sv
